>>> rtl/cpc_pkg.sv
package cpc_pkg;

    // fraction bits of the unit normal and the mass factors
    localparam int unsigned UNIT_BITS = 30;
    // fraction bits of the restitution register
    localparam int unsigned REST_BITS = 16;
    // one root bit per square-root stage
    localparam int unsigned SQRT_STEPS = 32;
    // one quotient bit per divider stage
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_LANES = 4;

    localparam logic [17:0] REST_RESET = 18'd65536;
    localparam logic [32:0] MASS_ONE = 33'h040000000;

    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

    // one input beat, unpacked
    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic [30:0]        a_radius;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic [30:0]        a_mass;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic [30:0]        b_radius;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic [30:0]        b_mass;
    } t_item;

    // per-item context carried down the pipeline
    typedef struct packed {
        logic               contact;
        logic               coincident;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic signed [31:0] apx;
        logic signed [31:0] apy;
        logic [30:0]        ar;
        logic [30:0]        am;
        logic [30:0]        bm;
        logic signed [33:0] cbx;
        logic signed [33:0] cby;
        logic [31:0]        rs;
        logic [31:0]        nxm;
        logic [31:0]        nym;
        logic               nxs;
        logic               nys;
    } t_ctx;

    // one result beat
    typedef struct packed {
        logic        contact;
        logic        coincident;
        logic [31:0] new_a_vel_x;
        logic [31:0] new_a_vel_y;
        logic [31:0] new_b_vel_x;
        logic [31:0] new_b_vel_y;
        logic [31:0] new_a_pos_x;
        logic [31:0] new_a_pos_y;
    } t_res;

    // product scaled down by 2^sh, truncated toward zero
    function automatic logic signed [71:0] tsh(input logic signed [71:0] p,
                                               input int unsigned sh);
        logic [71:0] m;
        m = p[71] ? 72'(-p) : 72'(p);
        m = m >> sh;
        return p[71] ? -$signed(m) : $signed(m);
    endfunction

    // saturate to 32-bit signed
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > S32_MAX) begin
            r = 32'h7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cpc_front.sv
module cpc_front import cpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  t_item       i_item,
    output logic        o_v,
    output t_ctx        o_ctx,
    output logic [63:0] o_dist2
);

    logic               r1_v, r2_v, r3_v;
    t_ctx               r1_ctx, r2_ctx, r3_ctx;
    logic               r1_small, r2_small;
    logic [63:0]        r2_sqx, r2_sqy, r2_rs2, r3_dist2;

    logic signed [34:0] w_cax, w_cay, w_cbx, w_cby, w_nx, w_ny;
    logic [34:0]        w_nxm, w_nym;
    t_ctx               w_ctx1, w_ctx3;
    logic [64:0]        w_sum;

    // centers and the center difference
    always_comb begin
        w_cax = 35'(i_item.a_pos_x) + $signed({4'b0, i_item.a_radius});
        w_cay = 35'(i_item.a_pos_y) + $signed({4'b0, i_item.a_radius});
        w_cbx = 35'(i_item.b_pos_x) + $signed({4'b0, i_item.b_radius});
        w_cby = 35'(i_item.b_pos_y) + $signed({4'b0, i_item.b_radius});
        w_nx  = w_cax - w_cbx;
        w_ny  = w_cay - w_cby;
        w_nxm = w_nx[34] ? -w_nx : w_nx;
        w_nym = w_ny[34] ? -w_ny : w_ny;

        w_ctx1.contact    = 1'b0;
        w_ctx1.coincident = (w_nx == 35'sd0) && (w_ny == 35'sd0);
        w_ctx1.avx        = i_item.a_vel_x;
        w_ctx1.avy        = i_item.a_vel_y;
        w_ctx1.bvx        = i_item.b_vel_x;
        w_ctx1.bvy        = i_item.b_vel_y;
        w_ctx1.apx        = i_item.a_pos_x;
        w_ctx1.apy        = i_item.a_pos_y;
        w_ctx1.ar         = i_item.a_radius;
        w_ctx1.am         = i_item.a_mass;
        w_ctx1.bm         = i_item.b_mass;
        w_ctx1.cbx        = w_cbx[33:0];
        w_ctx1.cby        = w_cby[33:0];
        w_ctx1.rs         = 32'({1'b0, i_item.a_radius} + {1'b0, i_item.b_radius});
        w_ctx1.nxm        = w_nxm[31:0];
        w_ctx1.nym        = w_nym[31:0];
        w_ctx1.nxs        = w_nx[34];
        w_ctx1.nys        = w_ny[34];
    end

    // touch test on the squared distance
    always_comb begin
        w_sum           = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        w_ctx3          = r2_ctx;
        w_ctx3.contact  = r2_small && !r2_ctx.coincident && (w_sum <= {1'b0, r2_rs2});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx   <= w_ctx1;
            r1_small <= (w_nxm[34:32] == 3'd0) && (w_nym[34:32] == 3'd0);
            r2_ctx   <= r1_ctx;
            r2_small <= r1_small;
            r2_sqx   <= 64'(r1_ctx.nxm) * 64'(r1_ctx.nxm);
            r2_sqy   <= 64'(r1_ctx.nym) * 64'(r1_ctx.nym);
            r2_rs2   <= 64'(r1_ctx.rs) * 64'(r1_ctx.rs);
            r3_ctx   <= w_ctx3;
            r3_dist2 <= w_sum[63:0];
        end
    end

    assign o_v     = r3_v;
    assign o_ctx   = r3_ctx;
    assign o_dist2 = r3_dist2;

endmodule

>>> rtl/cpc_sqrt.sv
module cpc_sqrt import cpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  t_ctx        i_ctx,
    input  logic [63:0] i_dist2,
    output logic        o_v,
    output t_ctx        o_ctx,
    output logic [31:0] o_root
);

    logic        r_v    [SQRT_STEPS];
    t_ctx        r_ctx  [SQRT_STEPS];
    logic [63:0] r_rem  [SQRT_STEPS];
    logic [63:0] r_root [SQRT_STEPS];

    // one root bit per stage, highest first
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (2 * SQRT_STEPS - 2 - 2 * k);
        logic        w_vi;
        t_ctx        w_ci;
        logic [63:0] w_remi, w_rooti, w_t;

        if (k == 0) begin : g_first
            assign w_vi    = i_v;
            assign w_ci    = i_ctx;
            assign w_remi  = i_dist2;
            assign w_rooti = 64'd0;
        end else begin : g_next
            assign w_vi    = r_v[k-1];
            assign w_ci    = r_ctx[k-1];
            assign w_remi  = r_rem[k-1];
            assign w_rooti = r_root[k-1];
        end

        assign w_t = w_rooti + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[k] <= w_ci;
                if (w_remi >= w_t) begin
                    r_rem[k]  <= w_remi - w_t;
                    r_root[k] <= (w_rooti >> 1) + BIT;
                end else begin
                    r_rem[k]  <= w_remi;
                    r_root[k] <= w_rooti >> 1;
                end
            end
        end
    end

    assign o_v    = r_v[SQRT_STEPS-1];
    assign o_ctx  = r_ctx[SQRT_STEPS-1];
    assign o_root = r_root[SQRT_STEPS-1][31:0];

endmodule

>>> rtl/cpc_div.sv
module cpc_div import cpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_v,
    input  t_ctx               i_ctx,
    input  logic [31:0]        i_root,
    output logic               o_v,
    output t_ctx               o_ctx,
    output logic signed [31:0] o_ux,
    output logic signed [31:0] o_uy,
    output logic [32:0]        o_fa,
    output logic [32:0]        o_fb
);

    // lanes: normal x, normal y by the distance; mass factors a, b by the mass sum
    logic                          r_v   [DIV_STEPS];
    t_ctx                          r_ctx [DIV_STEPS];
    logic [DIV_LANES-1:0][32:0]    r_rem [DIV_STEPS];
    logic [DIV_LANES-1:0][31:0]    r_nlo [DIV_STEPS];
    logic [DIV_LANES-1:0][31:0]    r_q   [DIV_STEPS];
    logic [DIV_LANES-1:0][32:0]    r_d   [DIV_STEPS];

    logic [DIV_LANES-1:0][62:0]    w_num;
    logic [DIV_LANES-1:0][32:0]    w_den;
    logic [32:0]                   w_msum;

    // dividends scaled by 2^30
    always_comb begin
        w_msum   = {2'b0, i_ctx.am} + {2'b0, i_ctx.bm};
        w_num[0] = 63'({i_ctx.nxm, 30'd0});
        w_num[1] = 63'({i_ctx.nym, 30'd0});
        w_num[2] = 63'({i_ctx.bm, 1'b0, 30'd0});
        w_num[3] = 63'({i_ctx.am, 1'b0, 30'd0});
        w_den[0] = {1'b0, i_root};
        w_den[1] = {1'b0, i_root};
        w_den[2] = (w_msum == 33'd0) ? 33'd1 : w_msum;
        w_den[3] = w_den[2];
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                       w_vi;
        t_ctx                       w_ci;
        logic [DIV_LANES-1:0][32:0] w_remi, w_di, w_remo;
        logic [DIV_LANES-1:0][31:0] w_nloi, w_qi, w_qo;

        if (k == 0) begin : g_first
            assign w_vi = i_v;
            assign w_ci = i_ctx;
            assign w_di = w_den;
            assign w_qi = '0;
            for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
                assign w_remi[l] = {2'b0, w_num[l][62:32]};
                assign w_nloi[l] = w_num[l][31:0];
            end
        end else begin : g_next
            assign w_vi   = r_v[k-1];
            assign w_ci   = r_ctx[k-1];
            assign w_di   = r_d[k-1];
            assign w_qi   = r_q[k-1];
            assign w_remi = r_rem[k-1];
            assign w_nloi = r_nlo[k-1];
        end

        always_comb begin
            logic [33:0] t;
            for (int l = 0; l < DIV_LANES; l++) begin
                t = {w_remi[l], w_nloi[l][31]};
                if (t >= {1'b0, w_di[l]}) begin
                    w_remo[l] = 33'(t - {1'b0, w_di[l]});
                    w_qo[l]   = {w_qi[l][30:0], 1'b1};
                end else begin
                    w_remo[l] = t[32:0];
                    w_qo[l]   = {w_qi[l][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[k] <= w_ci;
                r_d[k]   <= w_di;
                r_rem[k] <= w_remo;
                r_q[k]   <= w_qo;
                for (int l = 0; l < DIV_LANES; l++) begin
                    r_nlo[k][l] <= {w_nloi[l][30:0], 1'b0};
                end
            end
        end
    end

    // apply signs; both masses zero count as equal masses
    always_comb begin
        o_v   = r_v[DIV_STEPS-1];
        o_ctx = r_ctx[DIV_STEPS-1];
        o_ux  = o_ctx.nxs ? -$signed(r_q[DIV_STEPS-1][0]) : $signed(r_q[DIV_STEPS-1][0]);
        o_uy  = o_ctx.nys ? -$signed(r_q[DIV_STEPS-1][1]) : $signed(r_q[DIV_STEPS-1][1]);
        if (o_ctx.am == 31'd0 && o_ctx.bm == 31'd0) begin
            o_fa = MASS_ONE;
            o_fb = MASS_ONE;
        end else begin
            o_fa = {1'b0, r_q[DIV_STEPS-1][2]};
            o_fb = {1'b0, r_q[DIV_STEPS-1][3]};
        end
    end

endmodule

>>> rtl/cpc_resp.sv
module cpc_resp import cpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_v,
    input  t_ctx               i_ctx,
    input  logic signed [31:0] i_ux,
    input  logic signed [31:0] i_uy,
    input  logic [32:0]        i_fa,
    input  logic [32:0]        i_fb,
    input  logic [17:0]        i_rest,
    output logic               o_v,
    output t_res               o_res
);

    logic               r_v [6];
    t_ctx               r_ctx [6];

    logic signed [64:0] r1_px, r1_py, r1_qx, r1_qy;
    logic signed [31:0] r1_ux, r1_uy, r2_ux, r2_uy, r3_ux, r3_uy;
    logic signed [32:0] r1_fa, r1_fb, r2_fa, r2_fb;
    logic signed [35:0] r2_s;
    logic signed [35:0] r2_posx, r2_posy, r3_posx, r3_posy, r4_posx, r4_posy;
    logic signed [35:0] r5_posx, r5_posy, r6_posx, r6_posy;
    logic signed [68:0] r3_pja, r3_pjb;
    logic signed [68:0] r4_pax, r4_pay, r4_pbx, r4_pby;
    logic signed [37:0] r5_nvax, r5_nvay, r5_nvbx, r5_nvby;
    logic signed [56:0] r6_pax, r6_pay, r6_pbx, r6_pby;

    logic signed [32:0] w_dvx, w_dvy;
    logic signed [36:0] w_ja, w_jb;
    logic signed [18:0] w_e;

    assign w_dvx = 33'(i_ctx.avx) - 33'(i_ctx.bvx);
    assign w_dvy = 33'(i_ctx.avy) - 33'(i_ctx.bvy);
    assign w_ja  = 37'(tsh(72'(r3_pja), UNIT_BITS));
    assign w_jb  = 37'(tsh(72'(r3_pjb), UNIT_BITS));
    assign w_e   = $signed({1'b0, i_rest});

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_v;
            for (int k = 1; k < 6; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // response datapath of multiply and scale-and-add stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int k = 1; k < 6; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
            // relative velocity and radius sum onto the normal
            r1_px <= w_dvx * i_ux;
            r1_py <= w_dvy * i_uy;
            r1_qx <= $signed({1'b0, i_ctx.rs}) * i_ux;
            r1_qy <= $signed({1'b0, i_ctx.rs}) * i_uy;
            r1_ux <= i_ux;
            r1_uy <= i_uy;
            r1_fa <= $signed(i_fa);
            r1_fb <= $signed(i_fb);
            // normal speed and separated position
            r2_s    <= 36'(tsh(72'(r1_px), UNIT_BITS)) + 36'(tsh(72'(r1_py), UNIT_BITS));
            r2_posx <= 36'(r_ctx[0].cbx) + 36'(tsh(72'(r1_qx), UNIT_BITS))
                       - $signed({5'b0, r_ctx[0].ar});
            r2_posy <= 36'(r_ctx[0].cby) + 36'(tsh(72'(r1_qy), UNIT_BITS))
                       - $signed({5'b0, r_ctx[0].ar});
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            r2_fa   <= r1_fa;
            r2_fb   <= r1_fb;
            // impulses
            r3_pja  <= r2_s * r2_fa;
            r3_pjb  <= r2_s * r2_fb;
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_posx <= r2_posx;
            r3_posy <= r2_posy;
            // impulse along the normal
            r4_pax  <= w_ja * r3_ux;
            r4_pay  <= w_ja * r3_uy;
            r4_pbx  <= w_jb * r3_ux;
            r4_pby  <= w_jb * r3_uy;
            r4_posx <= r3_posx;
            r4_posy <= r3_posy;
            // new velocities
            r5_nvax <= 38'(r_ctx[3].avx) - 38'(tsh(72'(r4_pax), UNIT_BITS));
            r5_nvay <= 38'(r_ctx[3].avy) - 38'(tsh(72'(r4_pay), UNIT_BITS));
            r5_nvbx <= 38'(r_ctx[3].bvx) + 38'(tsh(72'(r4_pbx), UNIT_BITS));
            r5_nvby <= 38'(r_ctx[3].bvy) + 38'(tsh(72'(r4_pby), UNIT_BITS));
            r5_posx <= r4_posx;
            r5_posy <= r4_posy;
            // restitution
            r6_pax  <= r5_nvax * w_e;
            r6_pay  <= r5_nvay * w_e;
            r6_pbx  <= r5_nvbx * w_e;
            r6_pby  <= r5_nvby * w_e;
            r6_posx <= r5_posx;
            r6_posy <= r5_posy;
        end
    end

    // scale, saturate and select against pass-through
    always_comb begin
        o_v              = r_v[5];
        o_res.contact    = r_ctx[5].contact;
        o_res.coincident = r_ctx[5].coincident;
        if (r_ctx[5].contact) begin
            o_res.new_a_vel_x = sat32(tsh(72'(r6_pax), REST_BITS));
            o_res.new_a_vel_y = sat32(tsh(72'(r6_pay), REST_BITS));
            o_res.new_b_vel_x = sat32(tsh(72'(r6_pbx), REST_BITS));
            o_res.new_b_vel_y = sat32(tsh(72'(r6_pby), REST_BITS));
            o_res.new_a_pos_x = sat32(72'(r6_posx));
            o_res.new_a_pos_y = sat32(72'(r6_posy));
        end else begin
            o_res.new_a_vel_x = r_ctx[5].avx;
            o_res.new_a_vel_y = r_ctx[5].avy;
            o_res.new_b_vel_x = r_ctx[5].bvx;
            o_res.new_b_vel_y = r_ctx[5].bvy;
            o_res.new_a_pos_x = r_ctx[5].apx;
            o_res.new_a_pos_y = r_ctx[5].apy;
        end
    end

endmodule

>>> rtl/circle_pair_collision.sv
// Circle pair collision response.
// Slave stream: one beat per circle pair (positions, radii, velocities,
// masses of both circles). Master stream: one beat per pair with contact and
// coincident flags, both new velocities and the separated first position.
// Config channel: a beat on i_cfg_valid writes the restitution register;
// o_cfg_ready is always high. Write it only while no pair is in flight.
// From an accepted input beat to the output beat, a pair passes the center
// and touch test stages, the square root (one root bit per stage), the
// division (one quotient bit per stage), the multiply stages of the
// response and the output register.
// Throughput is one pair per cycle unless stalled; stages advance together.
// When the receiver stalls, the pipeline holds and o_s_axis_tready drops,
// except that a bubble in front of the output register is squeezed out, so
// new beats are taken while a result waits. Nothing is lost or repeated.
// Reset clears all valid bits and sets restitution to one (65536).
module circle_pair_collision import cpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_pos_x, a_pos_y, a_radius, a_vel_x, a_vel_y, a_mass,
    // b_pos_x, b_pos_y, b_radius, b_vel_x, b_vel_y, b_mass, zero pad
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // contact, coincident, new_a_vel_x, new_a_vel_y, new_b_vel_x,
    // new_b_vel_y, new_a_pos_x, new_a_pos_y, zero pad
    output logic [199:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [17:0]  i_cfg_data
);

    logic               r_rest;
    logic [17:0]        r_restitution;
    logic               r_out_v;
    t_res               r_out;

    logic               w_en;
    t_item              w_item;
    logic               w_f_v, w_s_v, w_d_v, w_pre_v;
    t_ctx               w_f_ctx, w_s_ctx, w_d_ctx;
    logic [63:0]        w_dist2;
    logic [31:0]        w_root;
    logic signed [31:0] w_ux, w_uy;
    logic [32:0]        w_fa, w_fb;
    t_res               w_res;

    // input beat unpack
    always_comb begin
        w_item.a_pos_x  = i_s_axis_tdata[31:0];
        w_item.a_pos_y  = i_s_axis_tdata[63:32];
        w_item.a_radius = i_s_axis_tdata[94:64];
        w_item.a_vel_x  = i_s_axis_tdata[126:95];
        w_item.a_vel_y  = i_s_axis_tdata[158:127];
        w_item.a_mass   = i_s_axis_tdata[189:159];
        w_item.b_pos_x  = i_s_axis_tdata[221:190];
        w_item.b_pos_y  = i_s_axis_tdata[253:222];
        w_item.b_radius = i_s_axis_tdata[284:254];
        w_item.b_vel_x  = i_s_axis_tdata[316:285];
        w_item.b_vel_y  = i_s_axis_tdata[348:317];
        w_item.b_mass   = i_s_axis_tdata[379:349];
    end

    // pipeline moves unless a finished result is blocked behind the output
    assign w_en            = i_m_axis_tready || !r_out_v || !w_pre_v;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // restitution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= REST_RESET;
            r_rest        <= 1'b0;
        end else if (i_cfg_valid) begin
            r_restitution <= i_cfg_data;
            r_rest        <= 1'b1;
        end
    end

    cpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (i_s_axis_tvalid),
        .i_item  (w_item),
        .o_v     (w_f_v),
        .o_ctx   (w_f_ctx),
        .o_dist2 (w_dist2)
    );

    cpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (w_f_v),
        .i_ctx   (w_f_ctx),
        .i_dist2 (w_dist2),
        .o_v     (w_s_v),
        .o_ctx   (w_s_ctx),
        .o_root  (w_root)
    );

    cpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (w_s_v),
        .i_ctx   (w_s_ctx),
        .i_root  (w_root),
        .o_v     (w_d_v),
        .o_ctx   (w_d_ctx),
        .o_ux    (w_ux),
        .o_uy    (w_uy),
        .o_fa    (w_fa),
        .o_fb    (w_fb)
    );

    cpc_resp u_resp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (w_d_v),
        .i_ctx   (w_d_ctx),
        .i_ux    (w_ux),
        .i_uy    (w_uy),
        .i_fa    (w_fa),
        .i_fb    (w_fb),
        .i_rest  (r_restitution),
        .o_v     (w_pre_v),
        .o_res   (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            r_out_v <= w_pre_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'd0, r_out.new_a_pos_y, r_out.new_a_pos_x,
                              r_out.new_b_vel_y, r_out.new_b_vel_x,
                              r_out.new_a_vel_y, r_out.new_a_vel_x,
                              r_out.coincident, r_out.contact};

    // a response is never applied to coincident centers
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.contact && r_out.coincident))
        else $error("contact and coincident both set");

    // a stalled finished result stays in front of the output register
    a_pre_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pre_v && !w_en) |=> w_pre_v)
        else $error("pipeline result dropped during stall");

    // the output beat only appears from a valid last stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(w_pre_v))
        else $error("output valid without a source beat");

    // restitution keeps its reset value until first written
    a_rest_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rest |-> (r_restitution == REST_RESET))
        else $error("restitution changed without a write");

endmodule
